// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the design files.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CHECK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property does not hold");

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_CHECK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

// ----- design/mrrpt_pkg.sv -----
// ---------------------------------------------------------------------------
// mrrpt_pkg
// Types and constants of the multi-reader ring pointer tracker.
// ---------------------------------------------------------------------------
package mrrpt_pkg;

   // Width of the ring length register and of all reported slot counts.
   localparam int LEN_BITS = 16;

   // Operation codes of a request.
   localparam logic [1:0] OP_HEAD  = 2'd0;
   localparam logic [1:0] OP_TAIL  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Register file.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RING_LENGTH    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_READERS = 2'd1;
   localparam logic [LEN_BITS-1:0] RING_LENGTH_RESET    = 16'd1024;
   localparam logic [3:0]          ACTIVE_READERS_RESET = 4'd0;

   // Shortest ring that is honored.
   localparam logic [LEN_BITS-1:0] MIN_RING_LENGTH = 16'd2;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [2:0]          reader_index;
      logic [LEN_BITS-1:0] amount;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [LEN_BITS-1:0] writer_free;
      logic [LEN_BITS-1:0] reader_available;
   } rsp_type;

endpackage

// ----- design/multi_reader_ring_pointer_tracker.sv -----
// Multi-reader ring pointer tracker. One writer head and up to MAX_READERS
// reader tails move around a ring of ring_length slots; each request commits
// a write, confirms a read or only queries, and yields one response with the
// writer's free space and the named reader's unread slots. The tails live in
// a small synchronous memory that is read, updated and written back; tails
// start at zero after reset through per-entry valid bits, so there is no
// clearing pass. A new request is accepted only once the last one is through;
// the free-space scan walks the active readers' tails one memory read and
// one remainder step at a time. Every read of a stored position that is at
// or above the current ring length (only after ring_length was lowered)
// goes through the full bit-serial pass of the shared remainder unit; the
// head and the named tail are each read twice per request and every scanned
// tail once. A finished response waits in the output register while the
// next request is taken.
// ---------------------------------------------------------------------------
// multi_reader_ring_pointer_tracker
// Head and tail pointer bookkeeping for a ring shared by several readers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_reader_ring_pointer_tracker #(
   parameter int MAX_READERS = 8,
   parameter int POS_BITS    = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Request channel.
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  mrrpt_pkg::req_type                       req_data,
   // Response channel.
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output mrrpt_pkg::rsp_type                       rsp_data,
   // Register write channel.
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mrrpt_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mrrpt_pkg::LEN_BITS-1:0]           csr_data
);

   localparam int LB        = mrrpt_pkg::LEN_BITS;
   localparam int RIDX_BITS = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_READERS + 1);
   localparam int WIDE      = (POS_BITS > LB) ? POS_BITS : LB;
   localparam int MCNT_BITS = $clog2(POS_BITS + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_HMOD  = 4'd2;
   localparam logic [3:0] S_TMOD  = 4'd3;
   localparam logic [3:0] S_UPD   = 4'd4;
   localparam logic [3:0] S_AH    = 4'd5;
   localparam logic [3:0] S_AHW   = 4'd6;
   localparam logic [3:0] S_ATW   = 4'd7;
   localparam logic [3:0] S_SRD   = 4'd8;
   localparam logic [3:0] S_SMOD  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   // Distance from one position to another going forward, both below len.
   function automatic logic [LB-1:0] fwd_gap(input logic [LB-1:0] from_pos,
                                             input logic [LB-1:0] to_pos,
                                             input logic [LB-1:0] len);
      logic [LB:0] sum;
      begin
         if (to_pos >= from_pos) begin
            sum = {1'b0, to_pos} - {1'b0, from_pos};
         end else begin
            sum = {1'b0, to_pos} + {1'b0, len} - {1'b0, from_pos};
         end
         fwd_gap = sum[LB-1:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [LB-1:0] ring_length_ff;
   logic [3:0]    active_readers_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_length_ff    <= mrrpt_pkg::RING_LENGTH_RESET;
         active_readers_ff <= mrrpt_pkg::ACTIVE_READERS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mrrpt_pkg::CSR_RING_LENGTH: begin
               ring_length_ff <= csr_data;
            end
            mrrpt_pkg::CSR_ACTIVE_READERS: begin
               active_readers_ff <= csr_data[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Declarations.
   // ------------------------------------------------------------------
   logic [3:0]           state_ff, state_in;
   logic [1:0]           op_ff;
   logic [2:0]           rd_ff;
   logic [LB-1:0]        amount_ff;
   logic [LB-1:0]        wlen_ff;
   logic [CNT_BITS-1:0]  nrd_ff;
   logic [LB-1:0]        h_ff, h_in;
   logic [LB-1:0]        t_ff, t_in;
   logic                 status_ff, status_in;
   logic [LB-1:0]        avail_ff, avail_in;
   logic [LB-1:0]        best_ff, best_in;
   logic [CNT_BITS-1:0]  scan_ff, scan_in;
   logic [POS_BITS-1:0]  head_ff, head_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mrrpt_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                 rsp_load;

   // Tail memory and its per-entry valid bits.
   logic [POS_BITS-1:0]    tail_mem [MAX_READERS];
   logic [MAX_READERS-1:0] tvalid_ff;
   logic                   mem_rd_en;
   logic [RIDX_BITS-1:0]   mem_rd_addr;
   logic [POS_BITS-1:0]    mem_rdata_ff;
   logic                   mem_rvalid_ff;
   logic                   mem_wr_en;
   logic [RIDX_BITS-1:0]   mem_wr_addr;
   logic [POS_BITS-1:0]    mem_wdata;
   logic [POS_BITS-1:0]    tail_val;

   // Remainder unit.
   logic                 mod_start;
   logic [POS_BITS-1:0]  mod_arg;
   logic                 mod_busy_ff;
   logic                 mod_done_ff;
   logic [LB-1:0]        mod_res_ff;
   logic [LB-1:0]        mod_rem_ff;
   logic [POS_BITS-1:0]  mod_sh_ff;
   logic [MCNT_BITS-1:0] mod_cnt_ff;
   logic [LB:0]          mod_shift;
   logic [LB:0]          mod_step;

   // Request decode.
   logic                 accept;
   logic                 rd_ok;
   logic [RIDX_BITS-1:0] rd_idx;
   logic [LB-1:0]        len_eff;
   logic [CNT_BITS-1:0]  n_eff;
   logic                 is_adv;
   logic                 bad_amount;
   logic [LB:0]          adv_sum;
   logic [LB-1:0]        adv_pos;
   logic [LB-1:0]        room;
   logic [LB-1:0]        raw_gap;
   logic [CNT_BITS-1:0]  scan_next;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign len_eff = (ring_length_ff < mrrpt_pkg::MIN_RING_LENGTH) ?
                    mrrpt_pkg::MIN_RING_LENGTH : ring_length_ff;
   assign n_eff   = (32'(active_readers_ff) > MAX_READERS) ?
                    CNT_BITS'(MAX_READERS) : CNT_BITS'(active_readers_ff);
   assign rd_ok   = (32'(rd_ff) < MAX_READERS);
   assign rd_idx  = RIDX_BITS'(rd_ff);

   // A tail that was never written reads as zero.
   assign tail_val = mem_rvalid_ff ? mem_rdata_ff : '0;

   // ------------------------------------------------------------------
   // Remainder unit: position modulo ring length. A position already
   // below the length is passed through unchanged; otherwise one quotient bit
   // is resolved per cycle by restoring subtraction.
   // ------------------------------------------------------------------
   assign mod_shift = {mod_rem_ff, mod_sh_ff[POS_BITS-1]};
   assign mod_step  = (mod_shift >= {1'b0, wlen_ff}) ?
                      mod_shift - {1'b0, wlen_ff} : mod_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
         mod_done_ff <= 1'b0;
      end else begin
         mod_done_ff <= 1'b0;
         if (mod_start) begin
            if (WIDE'(mod_arg) < WIDE'(wlen_ff)) begin
               mod_done_ff <= 1'b1;
            end else begin
               mod_busy_ff <= 1'b1;
            end
         end else if (mod_busy_ff && (mod_cnt_ff == MCNT_BITS'(1))) begin
            mod_busy_ff <= 1'b0;
            mod_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mod_start) begin
         mod_res_ff <= LB'(mod_arg);
         mod_rem_ff <= '0;
         mod_sh_ff  <= mod_arg;
         mod_cnt_ff <= MCNT_BITS'(POS_BITS);
      end else if (mod_busy_ff) begin
         mod_rem_ff <= mod_step[LB-1:0];
         mod_res_ff <= mod_step[LB-1:0];
         mod_sh_ff  <= mod_sh_ff << 1;
         mod_cnt_ff <= mod_cnt_ff - MCNT_BITS'(1);
      end
   end

   // ------------------------------------------------------------------
   // Tail memory: one write port, one registered read port.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         tail_mem[mem_wr_addr] <= mem_wdata;
      end
      if (mem_rd_en) begin
         mem_rdata_ff <= tail_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff     <= '0;
         mem_rvalid_ff <= 1'b0;
      end else begin
         if (mem_wr_en) begin
            tvalid_ff[mem_wr_addr] <= 1'b1;
         end
         if (mem_rd_en) begin
            mem_rvalid_ff <= tvalid_ff[mem_rd_addr];
         end
      end
   end

   // ------------------------------------------------------------------
   // Update arithmetic for the advance step.
   // ------------------------------------------------------------------
   assign is_adv     = (op_ff == mrrpt_pkg::OP_HEAD) || (op_ff == mrrpt_pkg::OP_TAIL);
   assign bad_amount = is_adv && (amount_ff > wlen_ff);
   assign adv_pos    = (op_ff == mrrpt_pkg::OP_HEAD) ? h_ff : t_ff;
   assign adv_sum    = ({1'b0, adv_pos} + {1'b0, amount_ff} >= {1'b0, wlen_ff}) ?
                       {1'b0, adv_pos} + {1'b0, amount_ff} - {1'b0, wlen_ff} :
                       {1'b0, adv_pos} + {1'b0, amount_ff};

   // Room in front of the writer for the tail being scanned.
   assign raw_gap   = fwd_gap(h_ff, mod_res_ff, wlen_ff);
   assign room      = (raw_gap == '0) ? wlen_ff - LB'(1) : raw_gap - LB'(1);
   assign scan_next = scan_ff + CNT_BITS'(1);

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      t_in         = t_ff;
      status_in    = status_ff;
      avail_in     = avail_ff;
      best_in      = best_ff;
      scan_in      = scan_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mod_start    = 1'b0;
      mod_arg      = head_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = rd_idx;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = rd_idx;
      mem_wdata    = POS_BITS'(adv_sum[LB-1:0]);

      // The response register drains independently of the sequencer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_START;
            end
         end
         // Reduce the head and fetch the named tail, before the update and again after it.
         S_START, S_AH: begin
            mod_start = 1'b1;
            mod_arg   = head_ff;
            mem_rd_en = 1'b1;
            state_in  = (state_ff == S_START) ? S_HMOD : S_AHW;
         end
         S_HMOD, S_AHW: begin
            if (mod_done_ff) begin
               h_in      = mod_res_ff;
               mod_start = 1'b1;
               mod_arg   = tail_val;
               state_in  = (state_ff == S_HMOD) ? S_TMOD : S_ATW;
            end
         end
         S_TMOD: begin
            if (mod_done_ff) begin
               t_in     = mod_res_ff;
               state_in = S_UPD;
            end
         end
         // Apply the advance and write the new position back.
         S_UPD: begin
            status_in = bad_amount;
            if (!bad_amount && (op_ff == mrrpt_pkg::OP_HEAD)) begin
               head_in = POS_BITS'(adv_sum[LB-1:0]);
            end
            if (!bad_amount && (op_ff == mrrpt_pkg::OP_TAIL) && rd_ok) begin
               mem_wr_en = 1'b1;
            end
            state_in = S_AH;
         end
         // Named reader's unread slots, then start the free-space scan.
         S_ATW: begin
            if (mod_done_ff) begin
               avail_in = rd_ok ? fwd_gap(mod_res_ff, h_ff, wlen_ff) : '0;
               best_in  = wlen_ff - LB'(1);
               scan_in  = '0;
               if (nrd_ff == '0) begin
                  state_in = S_OUT;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  state_in    = S_SRD;
               end
            end
         end
         S_SRD: begin
            mod_start = 1'b1;
            mod_arg   = tail_val;
            state_in  = S_SMOD;
         end
         S_SMOD: begin
            if (mod_done_ff) begin
               if (room < best_ff) begin
                  best_in = room;
               end
               scan_in = scan_next;
               if (scan_next == nrd_ff) begin
                  state_in = S_OUT;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = RIDX_BITS'(scan_next);
                  state_in    = S_SRD;
               end
            end
         end
         // Hand the response over once the output register is free.
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.status           = status_ff;
               rsp_data_in.writer_free      = best_ff;
               rsp_data_in.reader_available = avail_ff;
               state_in                     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The response register takes a new response in this cycle.
   assign rsp_load = (state_ff == S_OUT) && (state_in == S_IDLE);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the latched request.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.opcode;
         rd_ff     <= req_data.reader_index;
         amount_ff <= req_data.amount;
         wlen_ff   <= len_eff;
         nrd_ff    <= n_eff;
      end
      h_ff        <= h_in;
      t_ff        <= t_in;
      status_ff   <= status_in;
      avail_ff    <= avail_in;
      best_ff     <= best_in;
      scan_ff     <= scan_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `ASSERT_NEVER(a_mod_restart, clock, reset, mod_start && mod_busy_ff)
   `ASSERT_CHECK(a_idle_mod_quiet, clock, reset, (state_ff == S_IDLE) |-> !mod_busy_ff)
   `ASSERT_CHECK(a_mod_in_range, clock, reset, mod_done_ff |-> (mod_res_ff < wlen_ff))
   `ASSERT_CHECK(a_scan_bound, clock, reset, (state_ff == S_SRD) |-> (scan_ff < nrd_ff))
   `ASSERT_CHECK(a_free_in_range, clock, reset, rsp_load |=> (rsp_data_ff.writer_free < wlen_ff))

endmodule
